// ===== hw/rtl/hcbd_pkg.sv =====
// Shared types, codes and byte classification for the chunked body decoder.
package hcbd_pkg;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef enum logic [3:0] {
    MODE_SIZE,
    MODE_SIZE_CR,
    MODE_EXT,
    MODE_EXT_CR,
    MODE_DATA,
    MODE_END_CR,
    MODE_END_LF,
    MODE_TRAILER,
    MODE_TRAILER_CR
  } mode_t;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_DONE     = 2'd1,
    ST_BAD      = 2'd2,
    ST_TOOLARGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CLS_HEX,
    CLS_CR,
    CLS_LF,
    CLS_SEMI,
    CLS_OTHER
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t   cls;
    logic [3:0]  hex_val;
    logic [7:0]  data;
  } hcbd_item_t;

  typedef struct packed {
    logic        body_valid;
    logic [7:0]  out_byte;
    status_t     status;
  } hcbd_result_t;

  function automatic hcbd_item_t classify(input logic [7:0] b);
    hcbd_item_t it;
    it.data    = b;
    it.hex_val = 4'd0;
    it.cls     = CLS_OTHER;
    if (b >= 8'h30 && b <= 8'h39) begin
      it.cls     = CLS_HEX;
      it.hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      it.cls     = CLS_HEX;
      it.hex_val = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      it.cls     = CLS_HEX;
      it.hex_val = 4'(b - 8'h41 + 8'd10);
    end else if (b == CHAR_CR) begin
      it.cls = CLS_CR;
    end else if (b == CHAR_LF) begin
      it.cls = CLS_LF;
    end else if (b == CHAR_SEMI) begin
      it.cls = CLS_SEMI;
    end
    return it;
  endfunction

endpackage

// ===== hw/rtl/hcbd_fifo.sv =====
// Small register-based first-in first-out queue.
module hcbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on a lone write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/hcbd_front.sv =====
// Front end: classifies each incoming byte and queues it for the decoder.
module hcbd_front
  import hcbd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       push,
  output logic       full,
  output hcbd_item_t item,
  output logic       item_avail,
  input  logic       item_take
);

  hcbd_item_t                  cls_item;
  logic [$bits(hcbd_item_t)-1:0] head_bits;
  logic                        q_empty;

  assign cls_item   = classify(in_byte);
  assign item       = hcbd_item_t'(head_bits);
  assign item_avail = !q_empty;

  hcbd_fifo #(
    .WIDTH ($bits(hcbd_item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls_item),
    .full  (full),
    .pop   (item_take),
    .rdata (head_bits),
    .empty (q_empty)
  );

endmodule

// ===== hw/rtl/hcbd_back.sv =====
// Back end: chunk framing state machine, size and total counters, limit checks.
module hcbd_back
  import hcbd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_max_body_size,
  input  hcbd_item_t   item,
  input  logic         item_avail,
  output logic         item_take,
  input  logic         res_full,
  output logic         res_push,
  output hcbd_result_t res
);

  logic [31:0]           max_body_size_r;
  logic [COUNT_BITS-1:0] lim;
  mode_t                 mode_r, mode_nxt;
  status_t               status_r, status_nxt;
  logic [COUNT_BITS-1:0] chunk_left_r, chunk_left_nxt;
  logic [COUNT_BITS-1:0] body_total_r, body_total_nxt;
  logic [COUNT_BITS-1:0] digit;
  logic [COUNT_BITS-1:0] room;
  logic [COUNT_BITS:0]   line_sum;
  logic                  digit_over;
  logic                  line_over;
  logic                  fire;

  // The limit in force never exceeds what the counters can hold.
  generate
    if (COUNT_BITS >= 32) begin : g_lim_wide
      assign lim = COUNT_BITS'(max_body_size_r);
    end else begin : g_lim_narrow
      assign lim = (|max_body_size_r[31:COUNT_BITS]) ? '1
                                                     : max_body_size_r[COUNT_BITS-1:0];
    end
  endgenerate

  assign fire      = item_avail && !res_full;
  assign item_take = fire;
  assign res_push  = fire;

  assign digit      = {{(COUNT_BITS-4){1'b0}}, item.hex_val};
  assign room       = (lim - digit) >> 4;
  assign digit_over = (digit > lim) || (chunk_left_r > room);
  assign line_sum   = {1'b0, body_total_r} + {1'b0, chunk_left_r};
  assign line_over  = line_sum > {1'b0, lim};

  always_comb begin
    mode_nxt       = mode_r;
    status_nxt     = status_r;
    chunk_left_nxt = chunk_left_r;
    body_total_nxt = body_total_r;
    res.body_valid = 1'b0;
    res.out_byte   = 8'd0;
    if (status_r == ST_BUSY) begin
      case (mode_r)
        MODE_SIZE: begin
          case (item.cls)
            CLS_CR:   mode_nxt = MODE_SIZE_CR;
            CLS_SEMI: mode_nxt = MODE_EXT;
            CLS_HEX: begin
              if (digit_over) begin
                status_nxt = ST_TOOLARGE;
              end else begin
                chunk_left_nxt = {chunk_left_r[COUNT_BITS-5:0], item.hex_val};
              end
            end
            default:  status_nxt = ST_BAD;
          endcase
        end
        MODE_SIZE_CR, MODE_EXT_CR: begin
          if (item.cls == CLS_LF) begin
            // End of the size line: last chunk, oversize body, or data.
            if (chunk_left_r == '0) begin
              mode_nxt = MODE_TRAILER;
            end else if (line_over) begin
              status_nxt = ST_TOOLARGE;
            end else begin
              mode_nxt = MODE_DATA;
            end
          end else if (mode_r == MODE_SIZE_CR) begin
            status_nxt = ST_BAD;
          end else if (item.cls != CLS_CR) begin
            mode_nxt = MODE_EXT;
          end
        end
        MODE_EXT: begin
          if (item.cls == CLS_CR) begin
            mode_nxt = MODE_EXT_CR;
          end
        end
        MODE_DATA: begin
          res.body_valid = 1'b1;
          res.out_byte   = item.data;
          body_total_nxt = body_total_r + 1'b1;
          chunk_left_nxt = chunk_left_r - 1'b1;
          if (chunk_left_r == COUNT_BITS'(1)) begin
            mode_nxt = MODE_END_CR;
          end
        end
        MODE_END_CR: begin
          if (item.cls == CLS_CR) begin
            mode_nxt = MODE_END_LF;
          end else begin
            status_nxt = ST_BAD;
          end
        end
        MODE_END_LF: begin
          if (item.cls == CLS_LF) begin
            mode_nxt       = MODE_SIZE;
            chunk_left_nxt = '0;
          end else begin
            status_nxt = ST_BAD;
          end
        end
        MODE_TRAILER: begin
          if (item.cls == CLS_CR) begin
            mode_nxt = MODE_TRAILER_CR;
          end
        end
        MODE_TRAILER_CR: begin
          if (item.cls == CLS_LF) begin
            status_nxt = ST_DONE;
          end else if (item.cls != CLS_CR) begin
            mode_nxt = MODE_TRAILER;
          end
        end
        default: mode_nxt = MODE_SIZE;
      endcase
    end
    res.status = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_size_r <= 32'd1048576;
      mode_r          <= MODE_SIZE;
      status_r        <= ST_BUSY;
      chunk_left_r    <= '0;
      body_total_r    <= '0;
    end else begin
      if (cfg_we) begin
        max_body_size_r <= cfg_max_body_size;
      end
      if (fire) begin
        mode_r       <= mode_nxt;
        status_r     <= status_nxt;
        chunk_left_r <= chunk_left_nxt;
        body_total_r <= body_total_nxt;
      end
    end
  end

  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != ST_BUSY) |=> (status_r == $past(status_r)))
    else $error("final status changed after it was set");

  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DATA) |-> (chunk_left_r != '0))
    else $error("data mode with no bytes left in the chunk");

  a_data_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.body_valid) |-> (res.status == ST_BUSY && status_r == ST_BUSY))
    else $error("body word emitted outside of an active decode");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> (mode_r == $past(mode_r) && chunk_left_r == $past(chunk_left_r)))
    else $error("decoder state moved without consuming a word");

endmodule

// ===== hw/rtl/http_chunked_body_decoder_unit.sv =====
// Top level of the HTTP/1.1 chunked body decoder.
//
//   Channel   Direction  Handshake            Payload
//   input     in         push / full          in_byte
//   result    out        empty / pop          out_body_valid, out_byte, out_status
//   config    in         cfg_we               cfg_max_body_size
//
// One word in gives one word out; the block sustains one word per clock cycle while the result queue is not full.
// A word accepted into the input queue is decoded from the queue head and written
// to the result queue, from which it can be popped; the input queue and the result
// queue are the registers on that path, and a full result queue can hold it back.
// Reset is synchronous, clears both queues and the decoder state, and restores
// the default limit.
// Either side may stall freely: a full result queue holds the decoder, and the
// input queue keeps taking words until it too fills.
module http_chunked_body_decoder_unit
  import hcbd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic        push,
  output logic        full,
  output logic        out_body_valid,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_we,
  input  logic [31:0] cfg_max_body_size
);

  localparam int QUEUE_DEPTH = 4;

  hcbd_item_t                      item;
  logic                            item_avail;
  logic                            item_take;
  logic                            res_full;
  logic                            res_push;
  hcbd_result_t                    res;
  logic [$bits(hcbd_result_t)-1:0] head_bits;
  hcbd_result_t                    head;

  hcbd_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_byte),
    .push       (push),
    .full       (full),
    .item       (item),
    .item_avail (item_avail),
    .item_take  (item_take)
  );

  hcbd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_max_body_size (cfg_max_body_size),
    .item              (item),
    .item_avail        (item_avail),
    .item_take         (item_take),
    .res_full          (res_full),
    .res_push          (res_push),
    .res               (res)
  );

  hcbd_fifo #(
    .WIDTH ($bits(hcbd_result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (head_bits),
    .empty (empty)
  );

  assign head           = hcbd_result_t'(head_bits);
  assign out_body_valid = head.body_valid;
  assign out_byte       = head.out_byte;
  assign out_status     = head.status;

endmodule

// ===== bench/http_chunked_body_decoder_unit_test.sv =====
// Self-checking bench for the chunked body decoder: one long chunked stream, checked word by word.
`timescale 1ns / 1ps

module http_chunked_body_decoder_unit_test;
  import hcbd_pkg::*;

  localparam int          ITEMS         = 1800;
  localparam logic [31:0] LIMIT_OPEN    = 32'hFFFF_FFFF;
  localparam logic [31:0] LIMIT_DEFAULT = 32'd1048576;
  localparam logic [7:0]  CHAR_0        = 8'h30;
  localparam logic [7:0]  CHAR_9        = 8'h39;
  localparam logic [7:0]  CHAR_LOWER_A  = 8'h61;
  localparam logic [7:0]  CHAR_LOWER_F  = 8'h66;
  localparam logic [7:0]  CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0]  CHAR_UPPER_F  = 8'h46;

  typedef enum int {LIM_OPEN, LIM_DEFAULT, LIM_TIGHT, LIM_ZERO} limit_kind_t;
  typedef enum int {
    END_COMPLETE, END_EMPTY_TOKEN, END_BAD_DIGIT, END_BAD_SIZE_CR,
    END_SIZE_LIMIT, END_TOTAL_LIMIT, END_BAD_CHUNK_END
  } ending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_max_body_size = 32'd0;
  logic        full;
  logic        empty;
  logic        out_body_valid;
  logic [7:0]  out_byte;
  logic [1:0]  out_status;

  // Decoder state as the bench predicts it.
  mode_t       dec_mode = MODE_SIZE;
  logic [31:0] dec_left = 32'd0;
  logic [31:0] dec_total = 32'd0;
  logic [31:0] dec_limit = LIMIT_DEFAULT;
  status_t     dec_status = ST_BUSY;

  logic [7:0]   raw_bytes[$];
  hcbd_result_t owed_words[$];

  // Stream generator bookkeeping.
  int          gen_count = 0;
  logic [31:0] gen_total = 32'd0;
  logic [31:0] gen_limit = LIMIT_DEFAULT;
  ending_t     ending = END_COMPLETE;

  logic no_idle = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   n_bytes = 0;
  int   n_results = 0;
  int   n_data = 0;
  int   n_cfg = 0;
  int   n_fail = 0;

  http_chunked_body_decoder_unit #(
    .COUNT_BITS(32)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_byte          (in_byte),
    .push             (push),
    .full             (full),
    .out_body_valid   (out_body_valid),
    .out_byte         (out_byte),
    .out_status       (out_status),
    .empty            (empty),
    .pop              (pop),
    .cfg_we           (cfg_we),
    .cfg_max_body_size(cfg_max_body_size)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    if (b >= CHAR_0 && b <= CHAR_9) return {1'b1, 4'(b - CHAR_0)};
    if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) return {1'b1, 4'(b - CHAR_LOWER_A + 8'd10)};
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) return {1'b1, 4'(b - CHAR_UPPER_A + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] not_byte(input logic [7:0] x);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == x) b = x ^ 8'h01;
    return b;
  endfunction

  task automatic close_size_line();
    if (dec_left == 32'd0) begin
      dec_mode = MODE_TRAILER;
    end else if ({1'b0, dec_total} + {1'b0, dec_left} > {1'b0, dec_limit}) begin
      dec_status = ST_TOOLARGE;
    end else begin
      dec_mode = MODE_DATA;
    end
  endtask

  task automatic decode_step(input logic [7:0] b, output hcbd_result_t r);
    logic [4:0]  hv;
    logic [31:0] d;
    hv = hex_value(b);
    d = {28'd0, hv[3:0]};
    r.body_valid = 1'b0;
    r.out_byte = 8'h00;
    if (dec_status == ST_BUSY) begin
      case (dec_mode)
        MODE_SIZE: begin
          if (b == CHAR_CR) begin
            dec_mode = MODE_SIZE_CR;
          end else if (b == CHAR_SEMI) begin
            dec_mode = MODE_EXT;
          end else if (!hv[4]) begin
            dec_status = ST_BAD;
          end else if (d > dec_limit || dec_left > (dec_limit - d) / 32'd16) begin
            // The size would pass the limit once this digit is shifted in.
            dec_status = ST_TOOLARGE;
          end else begin
            dec_left = dec_left * 32'd16 + d;
          end
        end
        MODE_SIZE_CR: begin
          if (b == CHAR_LF) close_size_line();
          else dec_status = ST_BAD;
        end
        MODE_EXT: begin
          if (b == CHAR_CR) dec_mode = MODE_EXT_CR;
        end
        MODE_EXT_CR: begin
          if (b == CHAR_LF) close_size_line();
          else if (b != CHAR_CR) dec_mode = MODE_EXT;
        end
        MODE_DATA: begin
          r.body_valid = 1'b1;
          r.out_byte = b;
          dec_total = dec_total + 32'd1;
          dec_left = dec_left - 32'd1;
          if (dec_left == 32'd0) dec_mode = MODE_END_CR;
        end
        MODE_END_CR: begin
          if (b == CHAR_CR) dec_mode = MODE_END_LF;
          else dec_status = ST_BAD;
        end
        MODE_END_LF: begin
          if (b == CHAR_LF) begin
            dec_mode = MODE_SIZE;
            dec_left = 32'd0;
          end else begin
            dec_status = ST_BAD;
          end
        end
        MODE_TRAILER: begin
          if (b == CHAR_CR) dec_mode = MODE_TRAILER_CR;
        end
        MODE_TRAILER_CR: begin
          if (b == CHAR_LF) dec_status = ST_DONE;
          else if (b != CHAR_CR) dec_mode = MODE_TRAILER;
        end
        default: begin
          dec_mode = MODE_SIZE;
        end
      endcase
    end
    r.status = dec_status;
  endtask

  task automatic put_byte(input logic [7:0] b);
    raw_bytes.push_back(b);
    gen_count++;
  endtask

  // Hex digits without leading zeros, letters in random case.
  task automatic put_hex(input logic [31:0] v);
    int         top;
    logic [3:0] nib;
    top = 0;
    for (int i = 0; i < 8; i++) if (v[4*i +: 4] != 4'd0) top = i;
    for (int i = top; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) begin
        put_byte(8'(CHAR_0 + nib));
      end else begin
        put_byte(8'(($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + nib - 8'd10));
      end
    end
  endtask

  // Ends a size line, sometimes through an extension that may hold lone CRs.
  task automatic put_line_end();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      put_byte(CHAR_SEMI);
      n = $urandom_range(0, 6);
      repeat (n) put_byte($urandom_range(0, 3) == 0 ? CHAR_CR : not_byte(CHAR_LF));
    end
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
  endtask

  task automatic put_trailer();
    int n;
    n = $urandom_range(0, 8);
    repeat (n) put_byte($urandom_range(0, 3) == 0 ? CHAR_CR : not_byte(CHAR_LF));
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
  endtask

  task automatic put_chunk(input logic [31:0] n, input logic broken_end);
    int z;
    z = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (z) put_byte(CHAR_0);
    put_hex(n);
    put_line_end();
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
    if (!broken_end) begin
      put_byte(CHAR_CR);
      put_byte(CHAR_LF);
    end else if ($urandom_range(0, 1)) begin
      put_byte(not_byte(CHAR_CR));
    end else begin
      put_byte(CHAR_CR);
      put_byte(not_byte(CHAR_LF));
    end
    gen_total += n;
  endtask

  task automatic wait_drained();
    while (raw_bytes.size() != 0 || push || owed_words.size() != 0) @(negedge clk);
  endtask

  // The limit register is only touched once every owed word has come back.
  task automatic set_limit(input logic [31:0] v);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_max_body_size <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dec_limit = v;
    gen_limit = v;
    n_cfg++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : drive
    hcbd_result_t r;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_step(in_byte, r);
        owed_words.push_back(r);
        n_bytes++;
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (raw_bytes.size() == 0) begin
          push <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 17);
          push <= 1'b0;
        end else begin
          in_byte <= raw_bytes.pop_front();
          push <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    hcbd_result_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_results++;
        if (owed_words.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("word %0d came out with nothing owed", n_results);
        end else begin
          want = owed_words.pop_front();
          if (out_body_valid !== want.body_valid || out_byte !== want.out_byte ||
              out_status !== want.status) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("word %0d: expected valid %0b byte %02h status %0d", n_results,
                       want.body_valid, want.out_byte, want.status);
              $display("word %0d:      got valid %0b byte %02h status %0d", n_results,
                       out_body_valid, out_byte, out_status);
            end
          end
          if (want.body_valid) n_data++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  corner_data [10];
    logic [7:0]  b;
    limit_kind_t kind;
    int          budget;
    int          s;
    int          k;
    corner_data = '{8'h00, 8'hFF, CHAR_CR, CHAR_LF, CHAR_SEMI, CHAR_0, 8'h66, 8'h47,
                    8'h80, 8'h7F};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Size 0a in lower case, an extension holding a lone CR and a CR CR LF ending,
    // then data that looks like framing bytes.
    set_limit(LIMIT_OPEN);
    put_byte(CHAR_0);
    put_byte(CHAR_LOWER_A);
    put_byte(CHAR_SEMI);
    put_byte(CHAR_CR);
    put_byte(8'h78);
    put_byte(CHAR_CR);
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
    foreach (corner_data[i]) put_byte(corner_data[i]);
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
    gen_total = 32'd10;

    k = 0;
    while (gen_count < ITEMS) begin
      kind = (k < 4) ? limit_kind_t'(k) : limit_kind_t'($urandom_range(0, 3));
      k++;
      case (kind)
        LIM_ZERO: begin
          // Leading zeros of the next size still pass under a zero limit.
          set_limit(32'd0);
          repeat ($urandom_range(1, 3)) put_byte(CHAR_0);
        end
        LIM_TIGHT: begin
          // Chunks fill the limit exactly.
          budget = $urandom_range(1, 120);
          set_limit(gen_total + budget);
          while (budget > 0) begin
            s = $urandom_range(1, 40);
            if (s > budget) s = budget;
            put_chunk(s, 1'b0);
            budget -= s;
          end
        end
        default: begin
          set_limit(kind == LIM_OPEN ? LIMIT_OPEN : LIMIT_DEFAULT);
          repeat ($urandom_range(1, 5)) begin
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
            put_chunk(s, 1'b0);
          end
        end
      endcase
    end

    // Completion and every error are sticky, so the stream ends in one of them.
    set_limit($urandom_range(0, 1) ? LIMIT_OPEN : gen_total + $urandom_range(60, 200));
    no_idle = 1'b1;
    repeat (2) put_chunk($urandom_range(1, 20), 1'b0);
    ending = ending_t'($urandom_range(0, 6));
    case (ending)
      END_COMPLETE: begin
        put_hex(32'd0);
        put_line_end();
        put_trailer();
      end
      END_EMPTY_TOKEN: begin
        put_line_end();
        put_trailer();
      end
      END_BAD_DIGIT: begin
        if ($urandom_range(0, 1)) put_hex($urandom_range(1, 15));
        b = 8'($urandom_range(0, 255));
        while (hex_value(b) != 5'd0 || b == CHAR_CR || b == CHAR_SEMI) begin
          b = 8'($urandom_range(0, 255));
        end
        put_byte(b);
      end
      END_BAD_SIZE_CR: begin
        put_hex($urandom_range(1, 15));
        put_byte(CHAR_CR);
        put_byte(not_byte(CHAR_LF));
      end
      END_SIZE_LIMIT: begin
        if (gen_limit == LIMIT_OPEN) repeat (9) put_byte(CHAR_UPPER_F);
        else put_hex(gen_limit + 32'd1);
      end
      END_TOTAL_LIMIT: begin
        put_hex(gen_limit - gen_total + 32'd1);
        put_line_end();
      end
      default: begin
        put_chunk($urandom_range(1, 8), 1'b1);
      end
    endcase
    repeat (40) put_byte(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (8) @(posedge clk);
    n_fail += owed_words.size();
    $display("Sent %0d bytes of chunked body, %0d decoded as data, under %0d limit settings.",
             n_bytes, n_data, n_cfg);
    $display("Stream closed by %s, decoder left in %s.", ending.name(), dec_status.name());
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
